// ===== design/mbtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbtcp_pkg
// Shared types and constants for the Modbus TCP read-holding-registers
// responder: request/response payloads, controller commands and status.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

  typedef struct packed {
    logic [15:0]        transaction_id;
    logic [15:0]        protocol_id;
    logic [7:0]         unit_id;
    logic [7:0]         function_code;
    logic [15:0]        start_address;
    logic [15:0]        register_count;
    logic [8:0]         request_length;
    logic signed [7:0]  link_rssi;
  } req_t;

  typedef struct packed {
    logic        beat_kind;
    logic [15:0] reply_transaction_id;
    logic [15:0] reply_protocol_id;
    logic [15:0] mbap_length;
    logic [7:0]  reply_unit_id;
    logic [7:0]  reply_function_code;
    logic [7:0]  byte_count_or_exception;
    logic [63:0] data_word;
    logic [2:0]  registers_in_word;
    logic        last;
  } resp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic emit_hdr;
    logic emit_data;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drop;
    logic read_ok;
    logic last_beat;
  } status_t;

  localparam logic       BEAT_HEADER = 1'b0;
  localparam logic       BEAT_DATA   = 1'b1;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0] FC_EXC_FLAG     = 8'h80;

  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;

  localparam logic [15:0] UNMAPPED_VALUE = 16'hFFFF;
  localparam logic [15:0] MBAP_BASE_LEN  = 16'd3;

  localparam logic [8:0] MIN_RESPONSE_SPACE = 9'd9;
  localparam logic [8:0] MIN_REQ_LEN        = 9'd8;
  localparam logic [8:0] MIN_REQ_LEN_FIXED  = 9'd12;
  localparam logic [8:0] MIN_REQ_LEN_MULTI  = 9'd13;

  localparam logic       CFG_RSSI_ADDR  = 1'b0;
  localparam logic       CFG_RESP_SPACE = 1'b1;

  localparam logic [15:0] RSSI_ADDR_RESET  = 16'd0;
  localparam logic [8:0]  RESP_SPACE_RESET = 9'd260;

endpackage

// ===== design/mbtcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbtcp_ctrl
// Sequencer: accepts a request, issues the header beat unless the request is dropped,
// then the data beats for a valid read.
module mbtcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mbtcp_pkg::status_t status,
  output mbtcp_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_HDR;
      end
      ST_HDR: begin
        if (status.drop || !status.read_ok) state_next = ST_IDLE;
        else state_next = ST_DATA;
      end
      ST_DATA: begin
        if (status.last_beat) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign busy          = (state != ST_IDLE);
  assign cmd.load_req  = (state == ST_IDLE) && start;
  assign cmd.emit_hdr  = (state == ST_HDR) && !status.drop;
  assign cmd.emit_data = (state == ST_DATA);

endmodule

// ===== design/mbtcp_dpath.sv =====
// ----------------------------------------------------------------------------
// mbtcp_dpath
// Request latch, config registers, reply classification, beat builder and
// the output register.
// ----------------------------------------------------------------------------
module mbtcp_dpath #(
  parameter int MAX_READ_REGISTERS = 125,
  parameter int REGISTERS_PER_BEAT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  mbtcp_pkg::req_t    req,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  mbtcp_pkg::cmd_t    cmd,
  output mbtcp_pkg::status_t status,
  output mbtcp_pkg::resp_t   resp,
  output logic               resp_valid
);

  localparam int CW    = $clog2(MAX_READ_REGISTERS + 1);
  localparam int IW    = CW + 2;
  localparam int SLOTS = 4;

  mbtcp_pkg::req_t  req_q;
  mbtcp_pkg::resp_t resp_next;
  logic [15:0]      rssi_addr;
  logic [8:0]       resp_space;
  logic [15:0]      rssi_val;
  logic [IW-1:0]    done;

  logic [7:0]       fc;
  logic [8:0]       rlen;
  logic             cnt_ok;
  logic [CW-1:0]    count_n;
  logic [7:0]       byte_count;
  logic [IW-1:0]    idx [SLOTS];
  logic [SLOTS-1:0] slot_valid;
  logic [63:0]      word;
  logic [2:0]       nregs;
  logic [15:0]      addr;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_addr  <= mbtcp_pkg::RSSI_ADDR_RESET;
      resp_space <= mbtcp_pkg::RESP_SPACE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbtcp_pkg::CFG_RSSI_ADDR:  rssi_addr  <= cfg_data;
        mbtcp_pkg::CFG_RESP_SPACE: resp_space <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // request latch; RSSI register value is fixed for the whole transaction
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q    <= req;
      rssi_val <= 16'd0 - {{8{req.link_rssi[7]}}, req.link_rssi};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) done <= '0;
    else if (cmd.emit_data) done <= done + IW'(REGISTERS_PER_BEAT);
  end

  assign fc      = req_q.function_code;
  assign rlen    = req_q.request_length;
  assign cnt_ok  = (req_q.register_count != 16'd0) &&
                   (req_q.register_count <= 16'(MAX_READ_REGISTERS));
  assign count_n = req_q.register_count[CW-1:0];
  assign byte_count = 8'({count_n, 1'b0});

  assign status.drop = (rlen < mbtcp_pkg::MIN_REQ_LEN) ||
                       (resp_space < mbtcp_pkg::MIN_RESPONSE_SPACE) ||
                       (((fc == mbtcp_pkg::FC_READ_HOLDING) ||
                         (fc == mbtcp_pkg::FC_WRITE_SINGLE)) &&
                        (rlen < mbtcp_pkg::MIN_REQ_LEN_FIXED)) ||
                       ((fc == mbtcp_pkg::FC_WRITE_MULTI) &&
                        (rlen < mbtcp_pkg::MIN_REQ_LEN_MULTI));
  assign status.read_ok   = (fc == mbtcp_pkg::FC_READ_HOLDING) && cnt_ok;
  assign status.last_beat = (done + IW'(REGISTERS_PER_BEAT)) >= IW'(count_n);

  // one data beat: up to four register slots, first slot in the top bits
  always_comb begin
    word  = '0;
    nregs = '0;
    addr  = '0;
    for (int k = 0; k < SLOTS; k++) begin
      idx[k]        = done + IW'(k);
      slot_valid[k] = (k < REGISTERS_PER_BEAT) && (idx[k] < IW'(count_n));
      addr          = req_q.start_address + 16'(idx[k]);
      if (slot_valid[k]) begin
        word[16*(SLOTS-1-k) +: 16] = (addr == rssi_addr) ? rssi_val
                                                          : mbtcp_pkg::UNMAPPED_VALUE;
        nregs = nregs + 3'd1;
      end
    end
  end

  always_comb begin
    resp_next = '0;
    if (cmd.emit_data) begin
      resp_next.beat_kind         = mbtcp_pkg::BEAT_DATA;
      resp_next.data_word         = word;
      resp_next.registers_in_word = nregs;
      resp_next.last              = status.last_beat;
    end else begin
      resp_next.beat_kind            = mbtcp_pkg::BEAT_HEADER;
      resp_next.reply_transaction_id = req_q.transaction_id;
      resp_next.reply_protocol_id    = req_q.protocol_id;
      resp_next.reply_unit_id        = req_q.unit_id;
      if (status.read_ok) begin
        resp_next.reply_function_code     = mbtcp_pkg::FC_READ_HOLDING;
        resp_next.byte_count_or_exception = byte_count;
        resp_next.mbap_length = mbtcp_pkg::MBAP_BASE_LEN + 16'(byte_count);
        resp_next.last        = 1'b0;
      end else begin
        // bad count on a read is an illegal value; everything else is refused
        resp_next.reply_function_code = mbtcp_pkg::FC_EXC_FLAG | fc;
        resp_next.byte_count_or_exception =
          (fc == mbtcp_pkg::FC_READ_HOLDING) ? mbtcp_pkg::EXC_ILLEGAL_VALUE
                                             : mbtcp_pkg::EXC_ILLEGAL_FUNCTION;
        resp_next.mbap_length = mbtcp_pkg::MBAP_BASE_LEN;
        resp_next.last        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hdr || cmd.emit_data) resp <= resp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) resp_valid <= 1'b0;
    else resp_valid <= cmd.emit_hdr || cmd.emit_data;
  end

endmodule

// ===== design/modbus_tcp_register_responder_top.sv =====
// The header beat is built in ST_HDR and then registered onto resp with resp_valid.
// A read emits the header beat, then ceil(count / REGISTERS_PER_BEAT) data beats (32
// for 125 registers at 4 per beat); an exception emits the header alone, a drop none.
// The beat sequencer emits one beat per cycle; busy stays high until the last beat.
// Reset: synchronous; config returns to RSSI address 0, response space 260.
// Results are strobed for one cycle by resp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// modbus_tcp_register_responder_top
// Modbus TCP read-holding-registers responder: controller plus datapath.
// ----------------------------------------------------------------------------
module modbus_tcp_register_responder_top #(
  parameter int MAX_READ_REGISTERS = 125,
  parameter int REGISTERS_PER_BEAT = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mbtcp_pkg::req_t  req,
  output mbtcp_pkg::resp_t resp,
  output logic             resp_valid,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);

  mbtcp_pkg::cmd_t    cmd;
  mbtcp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mbtcp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  mbtcp_dpath #(
    .MAX_READ_REGISTERS (MAX_READ_REGISTERS),
    .REGISTERS_PER_BEAT (REGISTERS_PER_BEAT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .resp       (resp),
    .resp_valid (resp_valid)
  );

endmodule

// ===== tb/modbus_tcp_register_responder_top_tb.sv =====
// ----------------------------------------------------------------------------
// modbus_tcp_register_responder_top_tb
// Self-checking bench for the Modbus TCP read-holding-registers responder.
// Requests go in on the start/busy port and the configuration registers are
// written between phases. A scoreboard predicts every reply beat from the
// request and the current register settings. Each strobed beat is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module modbus_tcp_register_responder_top_tb;

  localparam int MAX_READ_REGS   = 125;
  localparam int REGS_PER_BEAT   = 4;
  localparam int SETTLE_CYCLES   = 6;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int RANDOM_PER_PHASE = 40;

  // Predicts reply beats and holds them until the block emits them.
  class reply_scoreboard;
    mbtcp_pkg::resp_t pending_beats[$];
    logic [15:0]      rssi_addr;
    logic [8:0]       resp_space;
    int               errors;
    int               requests;
    int               reads_ok;
    int               exceptions;
    int               drops;
    int               beats_checked;

    function new();
      rssi_addr  = mbtcp_pkg::RSSI_ADDR_RESET;
      resp_space = mbtcp_pkg::RESP_SPACE_RESET;
      errors = 0; requests = 0; reads_ok = 0;
      exceptions = 0; drops = 0; beats_checked = 0;
    endfunction

    function void write_register(logic idx, logic [15:0] data);
      if (idx == mbtcp_pkg::CFG_RSSI_ADDR) begin
        rssi_addr = data;
      end else begin
        resp_space = data[8:0];
      end
    endfunction

    function logic [15:0] register_value(logic [15:0] addr, logic signed [7:0] rssi);
      logic signed [15:0] wide;
      wide = rssi;
      if (addr != rssi_addr) return mbtcp_pkg::UNMAPPED_VALUE;
      if (rssi == 0) return '0;
      return -wide;
    endfunction

    function mbtcp_pkg::resp_t header_beat(mbtcp_pkg::req_t r, logic [7:0] fc,
                                           logic [7:0] code, logic [15:0] mbap,
                                           logic last_flag);
      mbtcp_pkg::resp_t b;
      b = '0;
      b.beat_kind               = mbtcp_pkg::BEAT_HEADER;
      b.reply_transaction_id    = r.transaction_id;
      b.reply_protocol_id       = r.protocol_id;
      b.mbap_length             = mbap;
      b.reply_unit_id           = r.unit_id;
      b.reply_function_code     = fc;
      b.byte_count_or_exception = code;
      b.last                    = last_flag;
      return b;
    endfunction

    function void note_request(mbtcp_pkg::req_t r);
      mbtcp_pkg::resp_t b;
      int               done;
      int               k;
      logic [15:0]      count;
      logic [15:0]      twice;
      logic [15:0]      addr;
      requests++;
      count = r.register_count;
      if (r.request_length < mbtcp_pkg::MIN_REQ_LEN ||
          resp_space < mbtcp_pkg::MIN_RESPONSE_SPACE) begin
        drops++;
        return;
      end
      case (r.function_code)
        mbtcp_pkg::FC_READ_HOLDING: begin
          if (r.request_length < mbtcp_pkg::MIN_REQ_LEN_FIXED) begin
            drops++;
            return;
          end
          if (count == 0 || count > MAX_READ_REGS) begin
            exceptions++;
            pending_beats.push_back(header_beat(r,
                                                mbtcp_pkg::FC_EXC_FLAG | r.function_code,
                                                mbtcp_pkg::EXC_ILLEGAL_VALUE,
                                                mbtcp_pkg::MBAP_BASE_LEN, 1'b1));
            return;
          end
          reads_ok++;
          twice = count << 1;
          pending_beats.push_back(header_beat(r, mbtcp_pkg::FC_READ_HOLDING, twice[7:0],
                                              mbtcp_pkg::MBAP_BASE_LEN + twice, 1'b0));
          done = 0;
          while (done < count) begin
            b = '0;
            b.beat_kind = mbtcp_pkg::BEAT_DATA;
            k = 0;
            while (k < REGS_PER_BEAT && done < count) begin
              addr = r.start_address + done[15:0];
              b.data_word[63 - 16 * k -: 16] = register_value(addr, r.link_rssi);
              k++;
              done++;
            end
            b.registers_in_word = k[2:0];
            b.last = (done >= count);
            pending_beats.push_back(b);
          end
        end
        mbtcp_pkg::FC_WRITE_SINGLE: begin
          if (r.request_length < mbtcp_pkg::MIN_REQ_LEN_FIXED) begin
            drops++;
            return;
          end
          exceptions++;
          pending_beats.push_back(header_beat(r, mbtcp_pkg::FC_EXC_FLAG | r.function_code,
                                              mbtcp_pkg::EXC_ILLEGAL_FUNCTION,
                                              mbtcp_pkg::MBAP_BASE_LEN, 1'b1));
        end
        mbtcp_pkg::FC_WRITE_MULTI: begin
          if (r.request_length < mbtcp_pkg::MIN_REQ_LEN_MULTI) begin
            drops++;
            return;
          end
          exceptions++;
          pending_beats.push_back(header_beat(r, mbtcp_pkg::FC_EXC_FLAG | r.function_code,
                                              mbtcp_pkg::EXC_ILLEGAL_FUNCTION,
                                              mbtcp_pkg::MBAP_BASE_LEN, 1'b1));
        end
        default: begin
          exceptions++;
          pending_beats.push_back(header_beat(r, mbtcp_pkg::FC_EXC_FLAG | r.function_code,
                                              mbtcp_pkg::EXC_ILLEGAL_FUNCTION,
                                              mbtcp_pkg::MBAP_BASE_LEN, 1'b1));
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t tb: mismatch on %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_beat(mbtcp_pkg::resp_t got);
      mbtcp_pkg::resp_t want;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t tb: unexpected beat, expected none, actual %h", $time, got);
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      compare_field("beat_kind", want.beat_kind, got.beat_kind);
      compare_field("reply_transaction_id", want.reply_transaction_id,
                    got.reply_transaction_id);
      compare_field("reply_protocol_id", want.reply_protocol_id, got.reply_protocol_id);
      compare_field("mbap_length", want.mbap_length, got.mbap_length);
      compare_field("reply_unit_id", want.reply_unit_id, got.reply_unit_id);
      compare_field("reply_function_code", want.reply_function_code,
                    got.reply_function_code);
      compare_field("byte_count_or_exception", want.byte_count_or_exception,
                    got.byte_count_or_exception);
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("registers_in_word", want.registers_in_word, got.registers_in_word);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  mbtcp_pkg::req_t  req;
  mbtcp_pkg::resp_t resp;
  logic             resp_valid;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [15:0]      cfg_data;

  reply_scoreboard sb = new();
  logic [15:0]     rssi_target;
  bit              gaps_on;
  int              settings_used;

  modbus_tcp_register_responder_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .resp       (resp),
    .resp_valid (resp_valid),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (start && !busy) sb.note_request(req);
      if (resp_valid) sb.check_beat(resp);
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function mbtcp_pkg::req_t build_request(logic [7:0] fc, logic [15:0] addr,
                                          logic [15:0] count, logic [8:0] rlen,
                                          logic [7:0] rssi);
    mbtcp_pkg::req_t r;
    r.transaction_id = 16'($urandom);
    r.protocol_id    = 16'($urandom);
    r.unit_id        = 8'($urandom);
    r.function_code  = fc;
    r.start_address  = addr;
    r.register_count = count;
    r.request_length = rlen;
    r.link_rssi      = rssi;
    return r;
  endfunction

  function mbtcp_pkg::req_t random_request();
    mbtcp_pkg::req_t r;
    int              pick;
    int              count;
    r = build_request(mbtcp_pkg::FC_READ_HOLDING, 16'($urandom), 16'($urandom),
                      9'($urandom_range(12, 511)), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 65) begin
      pick = $urandom_range(99);
      if (pick < 85) count = $urandom_range(1, 12);
      else if (pick < 95) count = $urandom_range(13, MAX_READ_REGS);
      else count = MAX_READ_REGS;
      r.register_count = 16'(count);
      // half of the reads cover the RSSI register
      if ($urandom_range(1))
        r.start_address = rssi_target - 16'($urandom_range(0, count - 1));
    end else if (pick < 75) begin
      r.register_count = $urandom_range(1) ? '0
                                           : 16'($urandom_range(MAX_READ_REGS + 1, 65535));
    end else if (pick < 82) begin
      r.function_code  = $urandom_range(1) ? mbtcp_pkg::FC_WRITE_SINGLE
                                           : mbtcp_pkg::FC_WRITE_MULTI;
      r.request_length = 9'($urandom_range(10, 14));
    end else if (pick < 90) begin
      r.function_code  = 8'($urandom);
      r.request_length = 9'($urandom_range(0, 511));
    end else begin
      r.request_length = 9'($urandom_range(0, 11));
    end
    return r;
  endfunction

  task automatic send_request(mbtcp_pkg::req_t r);
    if (gaps_on) begin
      while ($urandom_range(99) < 22) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Sender holds off until every predicted beat is out and dropped work is done.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] addr, logic [8:0] space);
    logic [15:0] data;
    wait_idle();
    data      = 16'($urandom);
    data[8:0] = space;
    write_cfg(mbtcp_pkg::CFG_RSSI_ADDR, addr);
    write_cfg(mbtcp_pkg::CFG_RESP_SPACE, data);
    rssi_target = addr;
    settings_used++;
  endtask

  task automatic random_phase(int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic directed_tests();
    mbtcp_pkg::req_t r;
    r = build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd12, -8'sd70);
    r.transaction_id = '1; r.protocol_id = '1; r.unit_id = '1;
    send_request(r);
    r = build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd12, 8'sd0);
    r.transaction_id = '0; r.protocol_id = '0; r.unit_id = '0;
    send_request(r);
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd12, 8'sd5));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd12,
                               -8'sd128));
    // address wrap through the RSSI register
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'hFFFE, 16'd6, 9'd511,
                               8'sd127));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0100, 16'd4, 9'd12,
                               -8'sd1));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0100, 16'd5, 9'd12,
                               -8'sd1));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'hFFC0, 16'd125, 9'd300,
                               -8'sd1));
    // bad counts
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd0, 9'd12, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd126, 9'd12,
                               8'sd0));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 9'd12,
                               8'sd0));
    // short requests
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd11, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd7, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_READ_HOLDING, 16'h0000, 16'd1, 9'd0, 8'sd0));
    // writes are refused
    send_request(build_request(mbtcp_pkg::FC_WRITE_SINGLE, 16'h0010, 16'd1, 9'd12, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_WRITE_SINGLE, 16'h0010, 16'd1, 9'd11, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_WRITE_MULTI, 16'h0010, 16'd2, 9'd13, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_WRITE_MULTI, 16'h0010, 16'd2, 9'd12, 8'sd0));
    // unknown codes
    send_request(build_request(8'h00, 16'h0000, 16'd1, 9'd8, 8'sd0));
    send_request(build_request(8'hFF, 16'h0000, 16'd1, 9'd511, 8'sd0));
    send_request(build_request(mbtcp_pkg::FC_EXC_FLAG | mbtcp_pkg::FC_READ_HOLDING,
                               16'h0000, 16'd1, 9'd8, 8'sd0));
    send_request(build_request(8'h01, 16'h0000, 16'd1, 9'd7, 8'sd0));
    send_request(build_request(8'h04, 16'h0000, 16'd1, 9'd255, 8'sd0));
  endtask

  initial begin
    int drain;
    rst           <= 1'b1;
    start         <= 1'b0;
    req           <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= mbtcp_pkg::CFG_RSSI_ADDR;
    cfg_data      <= '0;
    rssi_target    = mbtcp_pkg::RSSI_ADDR_RESET;
    gaps_on        = 1'b1;
    settings_used  = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_tests();

    set_config(16'hFFFF, 9'd9);
    random_phase(RANDOM_PER_PHASE);

    // replies suppressed
    set_config(16'($urandom), 9'd8);
    random_phase(8);

    // long stretch without idling
    set_config(16'h0000, 9'd511);
    gaps_on = 1'b0;
    random_phase(RANDOM_PER_PHASE);
    gaps_on = 1'b1;

    set_config(16'($urandom), 9'd0);
    random_phase(6);

    set_config(16'($urandom), 9'($urandom_range(9, 511)));
    random_phase(RANDOM_PER_PHASE);

    set_config(16'h8000, mbtcp_pkg::RESP_SPACE_RESET);
    random_phase(RANDOM_PER_PHASE);

    start <= 1'b0;
    drain = 0;
    while (sb.pending_beats.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES + 4) @(posedge clk);
    if (sb.pending_beats.size() != 0) begin
      sb.errors++;
      $display("%0t tb: %0d reply beats expected but never seen, next expected %h",
               $time, sb.pending_beats.size(), sb.pending_beats[0]);
    end

    $display("tb: %0d requests: %0d reads, %0d exceptions, %0d dropped; %0d beats checked",
             sb.requests, sb.reads_ok, sb.exceptions, sb.drops, sb.beats_checked);
    $display("tb: %0d register settings, response space 0, 8, 9, 260, 511 and random",
             settings_used);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbtcp_pkg.sv
design/mbtcp_ctrl.sv
design/mbtcp_dpath.sv
design/modbus_tcp_register_responder_top.sv
tb/modbus_tcp_register_responder_top_tb.sv
